FILE: rtl/core/x509_der_field_extractor_core_defines.svh
// Assertion macros shared by the X.509 DER field extractor RTL.
// Each macro assumes signals named clock and reset in the including module.
`ifndef X509_DER_FIELD_EXTRACTOR_CORE_DEFINES_SVH
`define X509_DER_FIELD_EXTRACTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define X509_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define X509_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

FILE: rtl/core/x509_der_pkg.sv
// Package for the X.509 DER field extractor: request and result types,
// element phase and TLV stage codes, and the field selection helper. No dependencies.
`default_nettype none

package x509_der_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] field_byte;
      logic       field_valid;
      logic       field_end;
      logic [1:0] status;
   } rsp_item_type;

   localparam int PHASE_W = 4;
   localparam int STAGE_W = 3;
   localparam int COUNT_W = 16;

   // Element phases, in the order the elements appear in the body.
   localparam logic [PHASE_W-1:0] PH_OUTER    = 4'd0;
   localparam logic [PHASE_W-1:0] PH_OPT_A0   = 4'd1;
   localparam logic [PHASE_W-1:0] PH_A0_LEN   = 4'd2;
   localparam logic [PHASE_W-1:0] PH_VERSION  = 4'd3;
   localparam logic [PHASE_W-1:0] PH_SERIAL   = 4'd4;
   localparam logic [PHASE_W-1:0] PH_SIGALG   = 4'd5;
   localparam logic [PHASE_W-1:0] PH_ISSUER   = 4'd6;
   localparam logic [PHASE_W-1:0] PH_VALIDITY = 4'd7;
   localparam logic [PHASE_W-1:0] PH_SUBJECT  = 4'd8;
   localparam logic [PHASE_W-1:0] PH_SPKI     = 4'd9;
   localparam logic [PHASE_W-1:0] PH_DONE     = 4'd10;

   // Position within one tag-length-value element.
   localparam logic [STAGE_W-1:0] ST_TAG    = 3'd0;
   localparam logic [STAGE_W-1:0] ST_LEN    = 3'd1;
   localparam logic [STAGE_W-1:0] ST_LEN81  = 3'd2;
   localparam logic [STAGE_W-1:0] ST_LEN82H = 3'd3;
   localparam logic [STAGE_W-1:0] ST_LEN82L = 3'd4;
   localparam logic [STAGE_W-1:0] ST_BODY   = 3'd5;

   localparam logic [1:0] SEL_ISSUER  = 2'd0;
   localparam logic [1:0] SEL_SUBJECT = 2'd1;
   localparam logic [1:0] SEL_SPKI    = 2'd2;
   localparam logic [1:0] SEL_RESET   = SEL_SUBJECT;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_LEN   = 2'd1;
   localparam logic [1:0] STATUS_TRUNCATED = 2'd2;

   localparam logic [7:0] TAG_CONTEXT0 = 8'hA0;
   localparam logic [7:0] TAG_INTEGER  = 8'h02;
   localparam logic [7:0] LEN_LONG1    = 8'h81;
   localparam logic [7:0] LEN_LONG2    = 8'h82;
   localparam logic [7:0] LEN_SHORT_MAX = 8'd127;

   function automatic logic is_selected(input logic [PHASE_W-1:0] phase,
                                        input logic [1:0] field_select);
      return (phase == PH_ISSUER  && field_select == SEL_ISSUER)  ||
             (phase == PH_SUBJECT && field_select == SEL_SUBJECT) ||
             (phase == PH_SPKI    && field_select == SEL_SPKI);
   endfunction

endpackage

`default_nettype wire

FILE: rtl/core/x509_der_parse.sv
// DER walk state and the per-byte step logic of the X.509 field extractor.
// Depends on x509_der_pkg.
`default_nettype none

module x509_der_parse
   import x509_der_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire logic [1:0]   field_select,
   input  wire req_item_type req_item,
   output rsp_item_type      rsp_item
);

   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [STAGE_W-1:0] stage_ff, stage_in;
   logic [COUNT_W-1:0] remain_ff, remain_in;
   logic               error_ff, error_in;
   logic               complete_ff, complete_in;

   always_comb begin
      logic [7:0] b;
      logic       valid;
      logic       fend;
      logic       finish;
      logic [1:0] status;

      b           = req_item.data_byte;
      phase_in    = phase_ff;
      stage_in    = stage_ff;
      remain_in   = remain_ff;
      error_in    = error_ff;
      complete_in = complete_ff;
      valid       = 1'b0;
      fend        = 1'b0;
      finish      = 1'b0;

      if (phase_ff >= PH_DONE) begin
         phase_in = PH_DONE;
      end else if (phase_ff == PH_A0_LEN) begin
         phase_in = PH_VERSION;
         stage_in = ST_TAG;
      end else begin
         unique case (stage_ff)
            ST_TAG: begin
               if (phase_ff == PH_OPT_A0 && b == TAG_CONTEXT0) begin
                  phase_in = PH_A0_LEN;
               end else begin
                  if (phase_in == PH_OPT_A0)
                     phase_in = PH_VERSION;
                  if (phase_in == PH_VERSION && b != TAG_INTEGER)
                     phase_in = PH_SERIAL;
                  if (phase_in == PH_SERIAL && b != TAG_INTEGER)
                     phase_in = PH_SIGALG;
                  valid    = is_selected(phase_in, field_select);
                  stage_in = ST_LEN;
               end
            end
            ST_LEN: begin
               if (b <= LEN_SHORT_MAX) begin
                  valid     = is_selected(phase_ff, field_select);
                  remain_in = {8'h00, b};
                  if (phase_ff == PH_OUTER || b == 8'h00)
                     finish = 1'b1;
                  else
                     stage_in = ST_BODY;
               end else if (b == LEN_LONG1) begin
                  valid    = is_selected(phase_ff, field_select);
                  stage_in = ST_LEN81;
               end else if (b == LEN_LONG2) begin
                  valid    = is_selected(phase_ff, field_select);
                  stage_in = ST_LEN82H;
               end else begin
                  // Indefinite or wider length forms stop the walk for this certificate.
                  error_in = 1'b1;
                  phase_in = PH_DONE;
                  stage_in = ST_TAG;
               end
            end
            ST_LEN81: begin
               valid     = is_selected(phase_ff, field_select);
               remain_in = {8'h00, b};
               if (phase_ff == PH_OUTER || b == 8'h00)
                  finish = 1'b1;
               else
                  stage_in = ST_BODY;
            end
            ST_LEN82H: begin
               valid     = is_selected(phase_ff, field_select);
               remain_in = {b, 8'h00};
               stage_in  = ST_LEN82L;
            end
            ST_LEN82L: begin
               valid     = is_selected(phase_ff, field_select);
               remain_in = {remain_ff[15:8], remain_ff[7:0] | b};
               if (phase_ff == PH_OUTER || remain_in == '0)
                  finish = 1'b1;
               else
                  stage_in = ST_BODY;
            end
            ST_BODY: begin
               valid = is_selected(phase_ff, field_select);
               if (remain_ff != '0)
                  remain_in = remain_ff - COUNT_W'(1);
               if (remain_in == '0)
                  finish = 1'b1;
            end
            default: begin
               phase_in = PH_DONE;
               stage_in = ST_TAG;
            end
         endcase
      end

      if (finish) begin
         if (is_selected(phase_ff, field_select)) begin
            complete_in = 1'b1;
            fend        = 1'b1;
         end
         phase_in = (phase_ff == PH_OUTER) ? PH_OPT_A0 : phase_ff + PHASE_W'(1);
         stage_in = ST_TAG;
      end

      if (error_in)
         status = STATUS_BAD_LEN;
      else if (req_item.last_byte && !complete_in)
         status = STATUS_TRUNCATED;
      else
         status = STATUS_OK;

      rsp_item.field_byte  = b;
      rsp_item.field_valid = valid;
      rsp_item.field_end   = fend;
      rsp_item.status      = status;

      // The final byte of a certificate restarts the walk.
      if (req_item.last_byte) begin
         phase_in    = PH_OUTER;
         stage_in    = ST_TAG;
         remain_in   = '0;
         error_in    = 1'b0;
         complete_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_OUTER;
         stage_ff    <= ST_TAG;
         remain_ff   <= '0;
         error_ff    <= 1'b0;
         complete_ff <= 1'b0;
      end else if (step) begin
         phase_ff    <= phase_in;
         stage_ff    <= stage_in;
         remain_ff   <= remain_in;
         error_ff    <= error_in;
         complete_ff <= complete_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/x509_der_field_extractor_core.sv
// X.509 to-be-signed DER field extractor. One request carries one certificate
// byte and yields one result: the byte, whether it belongs to the element chosen
// by the selection register (issuer, subject or public key info), an end mark and
// a status. The block sustains one request per clock cycle while results are taken
// as offered. A request is held in the input register while the combinational
// TLV step updates the parse state, and its result is then written to the result
// register and offered on rsp_valid; the input register and the result register
// lie between acceptance and result. A result waiting on rsp_ready stalls the input
// once the input register is also occupied. The final-byte flag restarts the
// parse. Write the selection register only while no request is in flight.
// Depends on x509_der_pkg, x509_der_parse and x509_der_field_extractor_core_defines.svh.
`default_nettype none

`include "x509_der_field_extractor_core_defines.svh"

module x509_der_field_extractor_core
   import x509_der_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_data,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [1:0]   csr_data
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;
   logic [1:0]   field_select_ff;
   rsp_item_type step_item;
   logic         step;
   logic         req_fire;

   // A held request moves on whenever the result register is free or draining.
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   always_comb begin
      if (req_fire)
         in_valid_in = 1'b1;
      else if (step)
         in_valid_in = 1'b0;
      else
         in_valid_in = in_valid_ff;

      if (step)
         out_valid_in = 1'b1;
      else if (rsp_ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   x509_der_parse u_parse (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .field_select (field_select_ff),
      .req_item     (in_item_ff),
      .rsp_item     (step_item)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         field_select_ff <= SEL_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_valid && csr_ready)
            field_select_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire)
         in_item_ff <= req_data;
      if (step)
         out_item_ff <= step_item;
   end

   `X509_ASSERT_SAME(a_end_is_valid, rsp_valid && rsp_data.field_end, rsp_data.field_valid)
   `X509_ASSERT_SAME(a_status_legal, rsp_valid, rsp_data.status != 2'd3)
   `X509_ASSERT_NEXT(a_step_fills_result, step, out_valid_ff)
   `X509_ASSERT_SAME(a_no_accept_when_full, in_valid_ff && out_valid_ff && !rsp_ready, !req_ready)

endmodule

`default_nettype wire
